### design/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared command codes and status types for the bounded deque.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CmdWidth  = 3;
  localparam int unsigned CapWidth  = 5;

  // command codes; the unused codes behave as a report
  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REPORT     = 3'd4
  } bdeq_cmd_e;

  // status that travels with each result
  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
  } bdeq_flags_t;

endpackage

### design/bdeq_store.sv
// ----------------------------------------------------------------------------
// bdeq_store
// Entry memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdeq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [AW-1:0]                   wr_addr_i,
  input  logic [bdeq_pkg::DataWidth-1:0]  wr_data_i,
  input  logic                            rd_en_i,
  input  logic [AW-1:0]                   rd_front_addr_i,
  input  logic [AW-1:0]                   rd_rear_addr_i,
  output logic [bdeq_pkg::DataWidth-1:0]  rd_front_o,
  output logic [bdeq_pkg::DataWidth-1:0]  rd_rear_o
);
  import bdeq_pkg::*;

  logic [DataWidth-1:0] mem [DEPTH];
  logic [DataWidth-1:0] rd_front_q;
  logic [DataWidth-1:0] rd_rear_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_front_q <= mem[rd_front_addr_i];
      rd_rear_q  <= mem[rd_rear_addr_i];
    end
  end

  assign rd_front_o = rd_front_q;
  assign rd_rear_o  = rd_rear_q;

endmodule

### design/bdeq_ctrl.sv
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Pointer, count and capacity control; sequences the memory access per
// transaction and holds the result status.
// ----------------------------------------------------------------------------
module bdeq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdeq_pkg::CapWidth-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bdeq_pkg::CmdWidth-1:0]  cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bdeq_pkg::bdeq_flags_t          flags_o,
  output logic                           wr_en_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic                           rd_en_o,
  output logic [AW-1:0]                  rd_front_addr_o,
  output logic [AW-1:0]                  rd_rear_addr_o
);
  import bdeq_pkg::*;

  localparam int unsigned KW = (CW > CapWidth) ? CW : CapWidth;
  localparam logic [KW-1:0] DepthK = KW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [CapWidth-1:0] cap_q;
  logic [AW-1:0]       front_q, front_d;
  logic [AW-1:0]       back_q, back_d;
  logic [CW-1:0]       count_q, count_d;
  logic                pend_q;
  bdeq_flags_t         pend_flags_q, new_flags;
  logic                out_valid_q;
  bdeq_flags_t         out_flags_q;

  logic          in_fire;
  logic          rd_en;
  logic [KW-1:0] cap_eff;
  logic          full_now;
  logic          empty_now;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  // handshake: memory read goes out once the output register is free
  assign rd_en      = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || rd_en;
  assign in_fire    = in_valid_i && in_ready_o;

  // effective capacity saturates at the store depth
  assign cap_eff   = (KW'(cap_q) > DepthK) ? DepthK : KW'(cap_q);
  assign full_now  = KW'(count_q) >= cap_eff;
  assign empty_now = (count_q == '0);

  // command decode and next pointer state
  always_comb begin
    front_d       = front_q;
    back_d        = back_q;
    count_d       = count_q;
    wr_en_o       = 1'b0;
    wr_addr_o     = back_q;
    new_flags.ok  = 1'b1;
    case (bdeq_cmd_e'(cmd_i))
      CMD_PUSH_FRONT: begin
        if (full_now) begin
          new_flags.ok = 1'b0;
        end else begin
          front_d   = wrap_dec(front_q);
          wr_addr_o = wrap_dec(front_q);
          wr_en_o   = in_fire;
          count_d   = count_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full_now) begin
          new_flags.ok = 1'b0;
        end else begin
          back_d    = wrap_inc(back_q);
          wr_addr_o = back_q;
          wr_en_o   = in_fire;
          count_d   = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty_now) begin
          new_flags.ok = 1'b0;
        end else begin
          front_d = wrap_inc(front_q);
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty_now) begin
          new_flags.ok = 1'b0;
        end else begin
          back_d  = wrap_dec(back_q);
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    new_flags.empty = (count_d == '0);
    new_flags.full  = KW'(count_d) >= cap_eff;
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapWidth'(16);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (in_fire) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // pending transaction and output status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_q <= 1'b1;
      end else if (rd_en) begin
        pend_q <= 1'b0;
      end
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_flags_q <= new_flags;
    end
    if (rd_en) begin
      out_flags_q <= pend_flags_q;
    end
  end

  assign rd_en_o         = rd_en;
  assign rd_front_addr_o = front_q;
  assign rd_rear_addr_o  = wrap_dec(back_q);
  assign out_valid_o     = out_valid_q;
  assign flags_o         = out_flags_q;

  // count never runs past the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KW'(count_q) <= DepthK)
    else $error("entry count exceeds depth");

  // a successful push adds exactly one entry
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && wr_en_o) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not increment count");

  // a pending transaction is not dropped while the output is stalled
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !rd_en) |=> pend_q)
    else $error("pending transaction lost");

  // a waiting result keeps its status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_flags_q)))
    else $error("stalled result changed");

endmodule

### design/bounded_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Bounded double-ended queue held in a ring memory with head and tail
// pointers; every command returns one status transaction.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | direction
//  ---------+----------------------------------------------+----------
//  command  | in_valid_i, in_ready_o, cmd_i, value_i       | in
//  result   | out_valid_o, out_ready_i, ok_o, front_value_o,| out
//           | rear_value_o, is_empty_o, is_full_o          |
//  config   | cfg_we_i, cfg_wdata_i (capacity)             | in
//
// A command is decoded and written to memory on its accept edge; the front
// and rear entries are read into the output register once it is free, and
// the result is then valid. The read of one command overlaps the accept of
// the next: one command per cycle sustained while results are taken.
// A stalled result holds the read; commands stall behind it after one more.
// Reset clears pointers, count and handshakes; capacity resets to 16.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bdeq_pkg::CapWidth-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bdeq_pkg::CmdWidth-1:0]         cmd_i,
  input  logic signed [bdeq_pkg::DataWidth-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  ok_o,
  output logic signed [bdeq_pkg::DataWidth-1:0] front_value_o,
  output logic signed [bdeq_pkg::DataWidth-1:0] rear_value_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);
  import bdeq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bdeq_flags_t          flags;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_front_addr;
  logic [AW-1:0]        rd_rear_addr;
  logic [DataWidth-1:0] rd_front;
  logic [DataWidth-1:0] rd_rear;

  // control
  bdeq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .flags_o         (flags),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .rd_en_o         (rd_en),
    .rd_front_addr_o (rd_front_addr),
    .rd_rear_addr_o  (rd_rear_addr)
  );

  // entry memory
  bdeq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i           (clk_i),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .wr_data_i       (value_i),
    .rd_en_i         (rd_en),
    .rd_front_addr_i (rd_front_addr),
    .rd_rear_addr_i  (rd_rear_addr),
    .rd_front_o      (rd_front),
    .rd_rear_o       (rd_rear)
  );

  // empty queue reports all ones for both ends
  assign ok_o          = flags.ok;
  assign is_empty_o    = flags.empty;
  assign is_full_o     = flags.full;
  assign front_value_o = flags.empty ? '1 : rd_front;
  assign rear_value_o  = flags.empty ? '1 : rd_rear;

endmodule

### sim/tb_bounded_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_top
// Drives push, pop and report commands at both ends of the bounded deque,
// changes the capacity between traffic phases and checks every status
// transaction against a cycle-free model of the ring store, with random
// idling on the command and result channels.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue_top;
  import bdeq_pkg::*;

  localparam int unsigned Depth         = 16;
  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned MaxIdle       = 16;
  localparam int unsigned LatencyCycles = 4;
  localparam int unsigned RandomItems   = 850;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned CycleLimit    = 400000;

  localparam logic [CapWidth-1:0] DepthCap      = CapWidth'(Depth);
  localparam logic [CapWidth-1:0] CapacityReset = CapWidth'(16);
  localparam logic [CapWidth-1:0] CapacityMax   = '1;
  localparam logic [CmdWidth-1:0] CmdUnusedLo   = CmdWidth'(CMD_REPORT + 1);
  localparam logic [CmdWidth-1:0] CmdUnusedHi   = '1;

  // one status transaction as the block reports it
  typedef struct packed {
    logic                 ok;
    logic [DataWidth-1:0] front;
    logic [DataWidth-1:0] rear;
    logic                 empty;
    logic                 full;
  } deque_status_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CapWidth-1:0]         cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [CmdWidth-1:0]         cmd_i;
  logic signed [DataWidth-1:0] value_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        ok_o;
  logic signed [DataWidth-1:0] front_value_o;
  logic signed [DataWidth-1:0] rear_value_o;
  logic                        is_empty_o;
  logic                        is_full_o;

  // model of the ring store
  logic [DataWidth-1:0] ring_words [Depth];
  logic [3:0]           ring_front    = '0;
  logic [3:0]           ring_back     = '0;
  logic [CapWidth-1:0]  ring_count    = '0;
  logic [CapWidth-1:0]  ring_capacity = CapacityReset;

  deque_status_t pending_status_q [$];
  int            error_count    = 0;
  int            cycle_count    = 0;
  bit            sender_idles   = 1'b1;
  bit            receiver_idles = 1'b1;

  bounded_double_ended_queue_top #(
    .DEPTH(Depth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .front_value_o(front_value_o),
    .rear_value_o (rear_value_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  // clock and cycle counter
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [DataWidth-1:0] want,
                             input logic [DataWidth-1:0] got);
    if (want !== got) begin
      report_mismatch($sformatf("%s expected %h got %h", name, want, got));
    end
  endtask

  // apply one command to the ring model and return the status it yields
  function automatic deque_status_t apply_deque_command(input logic [CmdWidth-1:0] cmd,
                                                        input logic [DataWidth-1:0] value);
    deque_status_t status;
    logic [CapWidth-1:0] limit;
    logic at_limit;
    limit    = (ring_capacity > DepthCap) ? DepthCap : ring_capacity;
    at_limit = (ring_count >= limit);
    status.ok = 1'b1;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (at_limit) begin
          status.ok = 1'b0;
        end else begin
          ring_front = ring_front - 4'd1;
          ring_words[ring_front] = value;
          ring_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (at_limit) begin
          status.ok = 1'b0;
        end else begin
          ring_words[ring_back] = value;
          ring_back = ring_back + 4'd1;
          ring_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (ring_count == '0) begin
          status.ok = 1'b0;
        end else begin
          ring_front = ring_front + 4'd1;
          ring_count--;
        end
      end
      CMD_POP_BACK: begin
        if (ring_count == '0) begin
          status.ok = 1'b0;
        end else begin
          ring_back = ring_back - 4'd1;
          ring_count--;
        end
      end
      // report and the unused codes leave the state alone
      default: ;
    endcase
    status.empty = (ring_count == '0);
    status.full  = (ring_count >= limit);
    status.front = status.empty ? '1 : ring_words[ring_front];
    status.rear  = status.empty ? '1 : ring_words[ring_back - 4'd1];
    return status;
  endfunction

  // result check first, then the prediction for a command taken on this edge
  always @(posedge clk_i) begin
    deque_status_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status_q.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          want = pending_status_q.pop_front();
          check_field("ok", DataWidth'(want.ok), DataWidth'(ok_o));
          check_field("front_value", want.front, front_value_o);
          check_field("rear_value", want.rear, rear_value_o);
          check_field("is_empty", DataWidth'(want.empty), DataWidth'(is_empty_o));
          check_field("is_full", DataWidth'(want.full), DataWidth'(is_full_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_status_q.push_back(apply_deque_command(cmd_i, value_i));
      end
    end
  end

  // result side: random stall before each transaction, ready held until taken
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = receiver_idles ? $urandom_range(0, MaxIdle) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // valid stays high on return; the caller either sends again or drains
  task automatic send_command(input logic [CmdWidth-1:0] cmd,
                              input logic [DataWidth-1:0] value);
    int gap;
    gap = sender_idles ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off commands until every outstanding status has come back;
  // the queue is sampled away from the rising edge so the checker has run
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_status_q.size() != 0) @(negedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    drain_results();
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= cap;
    ring_capacity = cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // empty queue after reset: failed pops, report and the unused codes
  task automatic test_empty_queue();
    send_command(CMD_REPORT, '0);
    send_command(CMD_POP_FRONT, '1);
    send_command(CMD_POP_BACK, $urandom);
    send_command(CmdUnusedLo, $urandom);
    send_command(CmdUnusedHi, $urandom);
  endtask

  // extreme words pushed and popped at both ends
  task automatic test_both_ends();
    send_command(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PUSH_BACK, '0);
    send_command(CMD_PUSH_FRONT, '1);
    send_command(CMD_REPORT, $urandom);
    send_command(CMD_POP_BACK, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    send_command(CMD_POP_BACK, $urandom);
  endtask

  // capacity of one and of zero
  task automatic test_capacity_limits();
    write_capacity(CapWidth'(1));
    send_command(CMD_PUSH_BACK, $urandom);
    send_command(CMD_PUSH_FRONT, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
    write_capacity('0);
    send_command(CMD_REPORT, $urandom);
    send_command(CMD_PUSH_BACK, $urandom);
  endtask

  // capacity dropped below the live count, after a saturating write
  task automatic test_shrunk_capacity();
    write_capacity(CapacityMax);
    repeat (3) send_command(CMD_PUSH_BACK, $urandom);
    write_capacity(CapWidth'(2));
    send_command(CMD_PUSH_FRONT, $urandom);
    send_command(CMD_POP_BACK, $urandom);
    send_command(CMD_POP_FRONT, $urandom);
  endtask

  // phases of random traffic, each with a set capacity and idling mix;
  // the push share swings so the queue runs between empty and full
  task automatic test_random_traffic();
    logic [CapWidth-1:0] phase_cap [PhaseCount];
    logic [CmdWidth-1:0] cmd;
    int push_share;
    int roll;
    phase_cap = '{CapacityReset, CapWidth'(1), CapWidth'(0), CapacityMax,
                  CapWidth'(5), CapWidth'(17), CapWidth'(9), CapacityReset};
    phase_cap[6] = CapWidth'($urandom_range(0, 31));
    push_share = 55;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      write_capacity(phase_cap[phase]);
      sender_idles   = (phase % 4 != 1) && (phase % 4 != 3);
      receiver_idles = (phase % 4 != 1) && (phase % 4 != 2);
      for (int n = 0; n < RandomItems / PhaseCount; n++) begin
        if (n % 24 == 0) begin
          push_share = 25 + 30 * $urandom_range(0, 2);
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          cmd = CmdWidth'($urandom_range(CMD_REPORT, CmdUnusedHi));
        end else if (roll < push_share) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        send_command(cmd, pick_value());
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // run limit
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // reset and test sequence
  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_REPORT;
    value_i     <= '0;
    out_ready_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_both_ends();
    test_capacity_limits();
    test_shrunk_capacity();
    test_random_traffic();
    drain_results();
    if (error_count == 0 && pending_status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/bdeq_pkg.sv
design/bdeq_store.sv
design/bdeq_ctrl.sv
design/bounded_double_ended_queue_top.sv
sim/tb_bounded_double_ended_queue_top.sv
